>>> rtl/core/vmcs_pkg.sv
// Shared types and constants for the value to MIDI control-change scaler.
package vmcs_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 27;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX     = 2'd2;

  localparam logic [7:0] CC_STATUS = 8'hB0;
  localparam logic [6:0] CC_TOP    = 7'd127;
  localparam int QuotW = 7;
  localparam int RemW = 35;

  typedef struct packed {
    logic accept;
    logic conv;
    logic setup;
    logic load;
    logic step;
    logic emit;
  } vmcs_cmd_t;

endpackage

>>> rtl/core/value_to_midi_cc_scaler_core.sv
// Top level of the value to MIDI control-change scaler.
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_carries_cc, in_cc_byte, in_value_bits
//  out     | output    | out_valid, out_stall, out_status_byte, out_controller_*
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// An accepted beat reaches the output register through a conversion step, a setup step, a load step,
// seven restoring divide steps and an emit step that waits until the output register is free.
// A new beat is taken once the current one is emitted.
// A finished message waits in the output register while the next beat is accepted.
// Reset restores channel 0, the span 0 to 1.0 and controller number 1.
module value_to_midi_cc_scaler_core import vmcs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_carries_cc,
  input  logic [7:0]          in_cc_byte,
  input  logic [31:0]         in_value_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_status_byte,
  output logic [6:0]          out_controller_number,
  output logic [6:0]          out_controller_value,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  vmcs_cmd_t cmd;

  vmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  vmcs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_carries_cc         (in_carries_cc),
    .in_cc_byte            (in_cc_byte),
    .in_value_bits         (in_value_bits),
    .out_status_byte       (out_status_byte),
    .out_controller_number (out_controller_number),
    .out_controller_value  (out_controller_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a beat was in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a beat in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("held result overwritten");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

>>> rtl/core/vmcs_dp.sv
// Datapath: configuration registers, float conversion, span mapping and serial divider.
module vmcs_dp import vmcs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vmcs_cmd_t           cmd,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_carries_cc,
  input  logic [7:0]          in_cc_byte,
  input  logic [31:0]         in_value_bits,
  output logic [7:0]          out_status_byte,
  output logic [6:0]          out_controller_number,
  output logic [6:0]          out_controller_value
);

  logic [3:0]                 chan_r;
  logic signed [CfgDataW-1:0] min_r;
  logic signed [CfgDataW-1:0] max_r;
  logic [6:0]                 cc_r;
  logic [31:0]                bits_r;
  logic signed [31:0]         v_r;
  logic                       nan_r;
  logic signed [33:0]         num_r;
  logic [27:0]                den_r;
  logic                       zero_r;
  logic                       skip_r;
  logic [QuotW-1:0]           res_r;
  logic [RemW-1:0]            rem_r;
  logic [RemW-1:0]            dv_r;
  logic [QuotW-1:0]           q_r;
  logic [7:0]                 status_r;
  logic [6:0]                 num_out_r;
  logic [6:0]                 val_out_r;

  logic signed [31:0] v_nxt;
  logic               nan_nxt;
  logic signed [33:0] num_nxt;
  logic [27:0]        den_nxt;
  logic               zero_nxt;
  logic               ge;

  always_comb begin
    logic       neg;
    logic [7:0] ex;
    logic [23:0] sig;
    logic signed [9:0] sh;
    logic [9:0] rs;
    logic [31:0] mag;
    logic       sat;
    neg = bits_r[31];
    ex  = bits_r[30:23];
    sig = {1'b1, bits_r[22:0]};
    sh  = $signed({2'b00, ex}) + $signed(10'(FRAC_BITS)) - 10'sd150;
    rs  = 10'(-sh);
    mag = '0;
    sat = 1'b0;
    nan_nxt = 1'b0;
    if (ex == 8'hFF) begin
      nan_nxt = (bits_r[22:0] != 23'd0);
      sat = !nan_nxt;
    end else if (ex == 8'h00) begin
      mag = '0;
    end else if (sh >= 10'sd8) begin
      sat = 1'b1;
    end else if (sh >= 10'sd0) begin
      mag = {8'b0, sig} << sh[2:0];
    end else if (rs >= 10'd25) begin
      mag = '0;
    end else begin
      mag = {8'b0, sig} >> rs[4:0];
    end
    if (sat) begin
      v_nxt = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      v_nxt = neg ? -$signed(mag) : $signed(mag);
    end
  end

  always_comb begin
    logic signed [27:0] den_raw;
    logic signed [33:0] num_raw;
    den_raw = $signed({max_r[CfgDataW-1], max_r}) - $signed({min_r[CfgDataW-1], min_r});
    num_raw = $signed({{2{v_r[31]}}, v_r}) - $signed({{7{min_r[CfgDataW-1]}}, min_r});
    if (den_raw[27]) begin
      den_nxt = 28'(-den_raw);
      num_nxt = -num_raw;
    end else begin
      den_nxt = den_raw;
      num_nxt = num_raw;
    end
    zero_nxt = nan_r || (den_raw == 28'sd0);
  end

  assign ge = (rem_r >= dv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      min_r  <= '0;
      max_r  <= CfgDataW'(1) << FRAC_BITS;
      cc_r   <= 7'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHANNEL: chan_r <= cfg_data[3:0];
          CFG_MIN:     min_r <= cfg_data;
          CFG_MAX:     max_r <= cfg_data;
          default:     ;
        endcase
      end
      if (cmd.accept && in_carries_cc) begin
        cc_r <= in_cc_byte[7] ? CC_TOP : in_cc_byte[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bits_r <= in_value_bits;
    end
    if (cmd.conv) begin
      v_r   <= v_nxt;
      nan_r <= nan_nxt;
    end
    if (cmd.setup) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      zero_r <= zero_nxt;
    end
    if (cmd.load) begin
      skip_r <= zero_r || (num_r <= 34'sd0) || (num_r >= $signed({6'b0, den_r}));
      res_r  <= (zero_r || (num_r <= 34'sd0)) ? '0 : CC_TOP;
      rem_r  <= RemW'(num_r[26:0]) * RemW'(254) + RemW'(den_r);
      dv_r   <= {den_r, 7'b0};
      q_r    <= '0;
    end
    if (cmd.step) begin
      rem_r <= ge ? rem_r - dv_r : rem_r;
      q_r   <= {q_r[QuotW-2:0], ge};
      dv_r  <= dv_r >> 1;
    end
    if (cmd.emit) begin
      status_r  <= CC_STATUS | {4'b0, chan_r};
      num_out_r <= cc_r;
      val_out_r <= skip_r ? res_r : q_r;
    end
  end

  assign out_status_byte       = status_r;
  assign out_controller_number = num_out_r;
  assign out_controller_value  = val_out_r;

endmodule

>>> rtl/core/vmcs_ctrl.sv
// Controller: sequences one beat through conversion, setup, load, the serial divide and emit.
module vmcs_ctrl import vmcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output vmcs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       free;

  assign free = !ovalid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(QuotW - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ovalid_nxt = cmd.emit ? 1'b1 : (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the value to MIDI control-change scaler core.
`timescale 1ns / 1ps

module tb import vmcs_pkg::*;;

  localparam int FRAC = 16;
  localparam int PHASE_BEATS = 125;
  localparam int HOLD_CYCLES = 200;
  localparam int LATENCY = 12;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic        carries;
    logic [7:0]  cc_byte;
    logic [31:0] bits;
    bit          pinned;
    logic [6:0]  want_cc;
    logic [6:0]  want_val;
  } beat_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] number;
    logic [6:0] value;
  } cc_msg_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [26:0] lo;
    logic [26:0] hi;
    bit          rnd;
  } span_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_carries_cc;
  logic [7:0] in_cc_byte;
  logic [31:0] in_value_bits;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_status_byte;
  logic [6:0] out_controller_number;
  logic [6:0] out_controller_value;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_CHANNEL;
  logic [CfgDataW-1:0] cfg_data = '0;
  beat_t cur_beat = '0;

  logic [3:0] chan_q = 4'd0;
  longint min_q = 0;
  longint max_q = 65536;
  logic [6:0] cc_now = 7'd1;
  cc_msg_t pending_msgs[$];
  int fail_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  beat_t directed_rows [23] = '{
    '{1'b0, 8'h00, 32'h0000_0000, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h3F80_0000, 1'b1, 7'd1, 7'd127},
    '{1'b0, 8'h00, 32'h3F00_0000, 1'b0, 7'd0, 7'd0},
    '{1'b0, 8'h00, 32'hBF80_0000, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h7F80_0000, 1'b1, 7'd1, 7'd127},
    '{1'b0, 8'h00, 32'hFF80_0000, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h7FC0_0000, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'hFFFF_FFFF, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h0000_0001, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h807F_FFFF, 1'b1, 7'd1, 7'd0},
    '{1'b0, 8'h00, 32'h7F7F_FFFF, 1'b1, 7'd1, 7'd127},
    '{1'b0, 8'h00, 32'h4700_0000, 1'b1, 7'd1, 7'd127},
    '{1'b0, 8'h00, 32'hC700_0000, 1'b1, 7'd1, 7'd0},
    '{1'b1, 8'h00, 32'h3E80_0000, 1'b0, 7'd0, 7'd0},
    '{1'b1, 8'h7F, 32'h3F80_0000, 1'b1, 7'd127, 7'd127},
    '{1'b1, 8'h80, 32'h0000_0000, 1'b1, 7'd127, 7'd0},
    '{1'b1, 8'hFF, 32'h3F80_0000, 1'b1, 7'd127, 7'd127},
    '{1'b1, 8'h55, 32'h3C00_0000, 1'b0, 7'd0, 7'd0},
    '{1'b0, 8'hAA, 32'h3F40_0000, 1'b0, 7'd0, 7'd0},
    '{1'b0, 8'h00, 32'h3A80_0000, 1'b0, 7'd0, 7'd0},
    '{1'b0, 8'h00, 32'h0080_0000, 1'b1, 7'd85, 7'd0},
    '{1'b0, 8'h00, 32'h3F80_0001, 1'b1, 7'd85, 7'd127},
    '{1'b0, 8'h00, 32'h3F7F_FFFF, 1'b0, 7'd0, 7'd0}
  };

  span_cfg_t span_plan [9] = '{
    '{4'd15, -27'sd65536000, 27'sd65536000, 1'b0},
    '{4'd6, 27'sd65536000, -27'sd65536000, 1'b0},
    '{4'd3, 27'sd1000, 27'sd1000, 1'b0},
    '{4'd9, 27'sd65536, 27'sd0, 1'b0},
    '{4'd12, -27'sd65536000, -27'sd65535873, 1'b0},
    '{4'd0, 27'sd0, 27'sd1, 1'b0},
    '{4'd10, 27'sd0, 27'sd0, 1'b1},
    '{4'd4, 27'sd0, 27'sd0, 1'b1},
    '{4'd0, 27'sd0, 27'sd65536, 1'b0}
  };

  assign in_carries_cc = cur_beat.carries;
  assign in_cc_byte = cur_beat.cc_byte;
  assign in_value_bits = cur_beat.bits;

  value_to_midi_cc_scaler_core #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_carries_cc(in_carries_cc),
    .in_cc_byte(in_cc_byte),
    .in_value_bits(in_value_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status_byte(out_status_byte),
    .out_controller_number(out_controller_number),
    .out_controller_value(out_controller_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint float_to_q16(input logic [31:0] bits, output bit nan);
    logic [7:0] ex;
    longint mag;
    longint sig;
    int sh;
    ex = bits[30:23];
    nan = 1'b0;
    if (ex == 8'hFF) begin
      if (bits[22:0] != 23'd0) begin
        nan = 1'b1;
        return 0;
      end
      mag = 64'sd1 << 40;
    end else if (ex == 8'h00) begin
      mag = 0;
    end else begin
      sig = {40'd0, 1'b1, bits[22:0]};
      sh = int'(ex) - 150 + FRAC;
      if (sh >= 40) mag = 64'sd1 << 40;
      else if (sh >= 0) mag = sig << sh;
      else if (-sh >= 25) mag = 0;
      else mag = sig >> (-sh);
    end
    if (bits[31]) begin
      if (mag > 64'sh8000_0000) mag = 64'sh8000_0000;
      return -mag;
    end
    if (mag > 64'sh7FFF_FFFF) mag = 64'sh7FFF_FFFF;
    return mag;
  endfunction

  function automatic logic [6:0] scale_to_cc(input longint v, input bit nan);
    longint num;
    longint den;
    longint q;
    den = max_q - min_q;
    num = v - min_q;
    if (nan || den == 0) return 7'd0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return 7'd0;
    if (num >= den) return CC_TOP;
    q = (2 * 127 * num + den) / (2 * den);
    if (q > 127) q = 127;
    return q[6:0];
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic beat_t draw_beat();
    beat_t b;
    int r;
    int p;
    longint t;
    longint m;
    longint mant;
    b = '0;
    b.carries = ($urandom_range(0, 99) < 30);
    b.cc_byte = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      t = min_q + (max_q - min_q) * (int'($urandom_range(0, 1200)) - 100) / 1000;
      t = t + $urandom_range(0, 6) - 3;
      m = (t < 0) ? -t : t;
      if (m == 0) begin
        b.bits = {$urandom_range(0, 1) == 1, 31'd0};
      end else begin
        p = 0;
        for (int i = 0; i < 48; i++) if (m[i]) p = i;
        mant = (p >= 23) ? (m >> (p - 23)) : (m << (23 - p));
        b.bits = {t < 0, 8'(p - FRAC + 127), mant[22:0]};
      end
    end else if (r < 75) begin
      b.bits = {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 160)), 23'($urandom)};
    end else if (r < 88) begin
      b.bits = $urandom;
    end else begin
      case ($urandom_range(0, 7))
        0: b.bits = 32'h0000_0000;
        1: b.bits = 32'h8000_0000;
        2: b.bits = 32'h7F80_0000;
        3: b.bits = 32'hFF80_0000;
        4: b.bits = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'd1};
        5: b.bits = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
        6: b.bits = 32'h7F7F_FFFF;
        default: b.bits = 32'hFF7F_FFFF;
      endcase
    end
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_beat <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    cc_msg_t want;
    bit nan;
    longint q;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL: chan_q = cfg_data[3:0];
          CFG_MIN: min_q = $signed(cfg_data);
          CFG_MAX: max_q = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_carries_cc) cc_now = (in_cc_byte > 8'd127) ? CC_TOP : in_cc_byte[6:0];
        q = float_to_q16(in_value_bits, nan);
        want.status = CC_STATUS | {4'h0, chan_q};
        want.number = cc_now;
        want.value = scale_to_cc(q, nan);
        if (cur_beat.pinned) begin
          want.status = CC_STATUS;
          want.number = cur_beat.want_cc;
          want.value = cur_beat.want_val;
        end
        pending_msgs.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_msgs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: output beat with nothing expected: %h %h %h", $realtime,
                     out_status_byte, out_controller_number, out_controller_value);
        end else begin
          want = pending_msgs.pop_front();
          if (out_status_byte !== want.status || out_controller_number !== want.number ||
              out_controller_value !== want.value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected status %h cc %0d value %0d, got %h %0d %0d",
                       $realtime, want.status, want.number, want.value,
                       out_status_byte, out_controller_number, out_controller_value);
          end
        end
      end
    end
  end

  initial begin : receiver
    int run;
    int hold;
    bit hold_done;
    run = 0;
    hold = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 40);
        run = idle_len() - 1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    longint lo;
    longint hi;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    foreach (span_plan[p]) begin
      drain();
      lo = $signed(span_plan[p].lo);
      hi = $signed(span_plan[p].hi);
      if (span_plan[p].rnd && span_plan[p].chan == 4'd10) begin
        lo = longint'($urandom_range(0, 131072000)) - 65536000;
        hi = longint'($urandom_range(0, 131072000)) - 65536000;
      end else if (span_plan[p].rnd) begin
        lo = longint'($urandom_range(0, 2000000)) - 1000000;
        hi = lo + $urandom_range(0, 4000) - 2000;
      end
      write_reg(CFG_UNUSED, CfgDataW'($urandom));
      write_reg(CFG_CHANNEL, {23'($urandom), span_plan[p].chan});
      write_reg(CFG_MIN, CfgDataW'(lo));
      write_reg(CFG_MAX, CfgDataW'(hi));
      cfg_we <= 1'b0;
      @(negedge clk);
      calm = (p != 1) && ($urandom_range(0, 3) == 0);
      if (p == 1) hold_req = 1'b1;
      repeat (PHASE_BEATS) send_beat(draw_beat());
    end

    drain();
    fail_count += pending_msgs.size();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
